// ----- hdl/tfd_pkg.sv -----
// tfd_pkg: shared widths, constants, side-band types and the CORDIC arctangent table
// for the transmit focus delay pipeline. No dependencies.
package tfd_pkg;

  // Datapath widths
  localparam int unsigned CW   = 27;  // CORDIC x, y and angle, Q24 signed
  localparam int unsigned DW   = 24;  // element-to-focus vector, Q4 signed
  localparam int unsigned AW   = 23;  // vector magnitudes, Q4 unsigned
  localparam int unsigned SQW  = 48;  // sum of squares
  localparam int unsigned RW   = 24;  // square root, Q4 distance
  localparam int unsigned OW   = 18;  // result field width
  localparam int unsigned RDW  = 30;  // angle range reduction

  // Probe kinds
  localparam logic [1:0] PROBE_LINEAR = 2'd0;
  localparam logic [1:0] PROBE_SPARSE = 2'd1;
  localparam logic [1:0] PROBE_PHASED = 2'd2;
  localparam logic [1:0] PROBE_CURVED = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_PROBE_KIND    = 3'd0;
  localparam logic [2:0] REG_ELEMENT_COUNT = 3'd1;
  localparam logic [2:0] REG_PITCH         = 3'd2;
  localparam logic [2:0] REG_F_NUMBER      = 3'd3;
  localparam logic [2:0] REG_RADIUS        = 3'd4;
  localparam logic [2:0] REG_ANGLE_STEP    = 3'd5;
  localparam logic [2:0] REG_SLOWNESS      = 3'd6;

  // Elements allowed to fire in sparse mode
  localparam logic [6:0] SPARSE_E0 = 7'd0;
  localparam logic [6:0] SPARSE_E1 = 7'd60;
  localparam logic [6:0] SPARSE_E2 = 7'd67;
  localparam logic [6:0] SPARSE_E3 = 7'd127;

  localparam logic [OW-1:0] SAT18 = 18'h3FFFF;

  // CORDIC gain and angles in Q24
  localparam logic signed [CW-1:0] GAIN_Q24    = 27'sd10188014;
  localparam logic signed [CW-1:0] PI_Q24      = 27'sd52707179;
  localparam logic signed [CW-1:0] HALF_PI_Q24 = 27'sd26353589;

  // Range reduction: thresholds pi, pi+2pi, pi+4pi and the matching subtrahends
  localparam logic signed [RDW-1:0] RED_T1 = 30'sd52707179;
  localparam logic signed [RDW-1:0] RED_T2 = 30'sd158121536;
  localparam logic signed [RDW-1:0] RED_T3 = 30'sd263535893;
  localparam logic signed [RDW-1:0] RED_S1 = 30'sd105414357;
  localparam logic signed [RDW-1:0] RED_S2 = 30'sd210828714;
  localparam logic signed [RDW-1:0] RED_S3 = 30'sd316243071;

  // Item data carried alongside the CORDIC
  typedef struct packed {
    logic [6:0]           element;
    logic signed [17:0]   fx;
    logic signed [17:0]   fz;
    logic signed [DW-1:0] lin_dx;
    logic                 flip;
  } tfd_geo_side_t;

  // Item data carried alongside the square root
  typedef struct packed {
    logic          active;
    logic [OW-1:0] lat;
  } tfd_res_side_t;

  function automatic logic signed [CW-1:0] atan_q24(input int unsigned idx);
    logic signed [CW-1:0] v;
    unique case (idx)
      0:  v = 27'sd13176795;
      1:  v = 27'sd7778716;
      2:  v = 27'sd4110060;
      3:  v = 27'sd2086331;
      4:  v = 27'sd1047214;
      5:  v = 27'sd524117;
      6:  v = 27'sd262123;
      7:  v = 27'sd131069;
      8:  v = 27'sd65536;
      9:  v = 27'sd32768;
      10: v = 27'sd16384;
      11: v = 27'sd8192;
      12: v = 27'sd4096;
      13: v = 27'sd2048;
      14: v = 27'sd1024;
      15: v = 27'sd512;
      16: v = 27'sd256;
      17: v = 27'sd128;
      18: v = 27'sd64;
      19: v = 27'sd32;
      20: v = 27'sd16;
      21: v = 27'sd8;
      22: v = 27'sd4;
      23: v = 27'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/tfd_in_if.sv -----
// tfd_in_if: input channel, one focus request word per handshake.
// Standalone; no package needed.
interface tfd_in_if;
  logic               valid;
  logic               ready;
  logic [6:0]         element;
  logic signed [17:0] focus_x_um;
  logic signed [17:0] focus_z_um;

  modport source (output valid, element, focus_x_um, focus_z_um, input ready);
  modport sink   (input valid, element, focus_x_um, focus_z_um, output ready);
endinterface

// ----- hdl/tfd_out_if.sv -----
// tfd_out_if: result channel, one delay word per handshake.
// Standalone; no package needed.
interface tfd_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] delay_ns;
  logic        active;
  logic [17:0] lateral_offset_um;

  modport source (output valid, delay_ns, active, lateral_offset_um, input ready);
  modport sink   (input valid, delay_ns, active, lateral_offset_um, output ready);
endinterface

// ----- hdl/transmit_focus_delay.sv -----
// transmit_focus_delay: top level. Element placement, distance, aperture and delay.
// Uses tfd_pkg, tfd_in_if, tfd_out_if, tfd_front, tfd_cordic and tfd_isqrt.
//
//  channel  | dir | word fields                              | handshake
//  ---------+-----+------------------------------------------+------------------
//  din_i    | in  | element, focus_x_um, focus_z_um          | valid/ready
//  dout_o   | out | delay_ns, active, lateral_offset_um      | valid/ready
//  cfg      | in  | cfg_idx_i, cfg_wdata_i                   | cfg_we_i, no wait
//
// One word in and one word out per clock while the output register is not held by dout_o.ready;
// the stages are 4 front stages, one per CORDIC iteration, 6 geometry/square stages,
// 24 square-root stages, the multiply and the output register.
// Reset clears all valid bits and loads register defaults; pipeline data is not reset.
// A word held in the output register with dout_o.ready low freezes every stage
// together, so nothing is dropped or duplicated; din_i.ready stays low while it is held.
module transmit_focus_delay #(
  parameter int unsigned CORDIC_STAGES = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [20:0] cfg_wdata_i,
  tfd_in_if.sink      din_i,
  tfd_out_if.source   dout_o
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [1:0]  probe_kind_q;
  logic [7:0]  element_count_q;
  logic [10:0] pitch_q;
  logic [9:0]  f_number_q;
  logic [16:0] radius_q;
  logic [20:0] angle_step_q;
  logic [17:0] slowness_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_kind_q    <= tfd_pkg::PROBE_LINEAR;
      element_count_q <= 8'd128;
      pitch_q         <= 11'd300;
      f_number_q      <= 10'd32;
      radius_q        <= '0;
      angle_step_q    <= '0;
      slowness_q      <= 18'd42556;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfd_pkg::REG_PROBE_KIND:    probe_kind_q    <= cfg_wdata_i[1:0];
        tfd_pkg::REG_ELEMENT_COUNT: element_count_q <= cfg_wdata_i[7:0];
        tfd_pkg::REG_PITCH:         pitch_q         <= cfg_wdata_i[10:0];
        tfd_pkg::REG_F_NUMBER:      f_number_q      <= cfg_wdata_i[9:0];
        tfd_pkg::REG_RADIUS:        radius_q        <= cfg_wdata_i[16:0];
        tfd_pkg::REG_ANGLE_STEP:    angle_step_q    <= cfg_wdata_i;
        tfd_pkg::REG_SLOWNESS:      slowness_q      <= cfg_wdata_i[17:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Global advance: the pipeline moves when the output slot is free
  // ---------------------------------------------------------------
  logic out_v_q;
  logic en;

  assign en          = !out_v_q || dout_o.ready;
  assign din_i.ready = en;

  // ---------------------------------------------------------------
  // Angle preparation and CORDIC
  // ---------------------------------------------------------------
  logic                          front_v;
  logic signed [tfd_pkg::CW-1:0] front_a;
  tfd_pkg::tfd_geo_side_t        front_s;

  tfd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (din_i.valid),
    .element_i       (din_i.element),
    .fx_i            (din_i.focus_x_um),
    .fz_i            (din_i.focus_z_um),
    .element_count_i (element_count_q),
    .pitch_i         (pitch_q),
    .angle_step_i    (angle_step_q),
    .valid_o         (front_v),
    .angle_o         (front_a),
    .side_o          (front_s)
  );

  logic                          cor_v;
  logic signed [tfd_pkg::CW-1:0] cor_c, cor_s;
  tfd_pkg::tfd_geo_side_t        cor_side;

  tfd_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .angle_i (front_a),
    .side_i  (front_s),
    .valid_o (cor_v),
    .cos_o   (cor_c),
    .sin_o   (cor_s),
    .side_o  (cor_side)
  );

  // ---------------------------------------------------------------
  // P1: undo the quadrant fold
  // ---------------------------------------------------------------
  logic                          p1_v_q;
  logic signed [tfd_pkg::CW-1:0] p1_s_q, p1_c_q;
  tfd_pkg::tfd_geo_side_t        p1_side_q;

  // P2: radius times sine and cosine
  logic                   p2_v_q;
  logic signed [44:0]     p2_ps_q, p2_pc_q;
  tfd_pkg::tfd_geo_side_t p2_side_q;
  logic signed [44:0]     rad45;

  assign rad45 = $signed({28'd0, radius_q});

  // P3: element position to Q4, vector to focus
  logic signed [44:0]             ex45, ez45;
  logic signed [24:0]             ex, ez;
  logic signed [tfd_pkg::DW-1:0]  fx16, fz16, dx_d, dz_d;
  logic signed [25:0]             curv_dx;

  assign ex45    = (p2_ps_q + 45'sd524288) >>> 20;
  assign ez45    = (p2_pc_q + 45'sd524288) >>> 20;
  assign ex      = ex45[24:0];
  assign ez      = ez45[24:0] - $signed({4'd0, radius_q, 4'd0});
  assign fx16    = tfd_pkg::DW'(p2_side_q.fx) <<< 4;
  assign fz16    = tfd_pkg::DW'(p2_side_q.fz) <<< 4;
  assign curv_dx = 26'(fx16) - 26'(ex);

  always_comb begin
    if (probe_kind_q == tfd_pkg::PROBE_CURVED) begin
      dx_d = curv_dx[tfd_pkg::DW-1:0];
      dz_d = fz16 - tfd_pkg::DW'(ez);
    end else begin
      dx_d = p2_side_q.lin_dx;
      dz_d = fz16;
    end
  end

  logic                          p3_v_q;
  logic signed [tfd_pkg::DW-1:0] p3_dx_q, p3_dz_q;
  logic [6:0]                    p3_e_q;

  // P4: magnitudes
  logic [tfd_pkg::DW-1:0] ax_w, az_w;

  assign ax_w = p3_dx_q[tfd_pkg::DW-1] ? tfd_pkg::DW'(-p3_dx_q) : p3_dx_q;
  assign az_w = p3_dz_q[tfd_pkg::DW-1] ? tfd_pkg::DW'(-p3_dz_q) : p3_dz_q;

  logic                   p4_v_q;
  logic [tfd_pkg::AW-1:0] p4_ax_q, p4_az_q;
  logic [6:0]             p4_e_q;

  // P5: squares, aperture product, rounded lateral offset
  logic [19:0]     lat_w;
  logic [17:0]     lat_sat;

  assign lat_w   = 20'((24'(p4_ax_q) + 24'd8) >> 4);
  assign lat_sat = (lat_w > 20'(tfd_pkg::SAT18)) ? tfd_pkg::SAT18 : lat_w[17:0];

  logic          p5_v_q;
  logic [45:0]   p5_sqx_q, p5_sqz_q;
  logic [33:0]   p5_apt_q;
  logic [26:0]   p5_az16_q;
  logic [17:0]   p5_lat_q;
  logic [6:0]    p5_e_q;

  // P6: sum of squares and the firing decision
  logic aperture_cut, sparse_hit, active_w;
  tfd_pkg::tfd_res_side_t p6_side_d;

  assign aperture_cut = p5_apt_q > 34'(p5_az16_q);
  assign sparse_hit   = (p5_e_q == tfd_pkg::SPARSE_E0) || (p5_e_q == tfd_pkg::SPARSE_E1) ||
                        (p5_e_q == tfd_pkg::SPARSE_E2) || (p5_e_q == tfd_pkg::SPARSE_E3);

  always_comb begin
    active_w = 1'b1;
    if ((probe_kind_q == tfd_pkg::PROBE_LINEAR || probe_kind_q == tfd_pkg::PROBE_SPARSE)
        && aperture_cut) begin
      active_w = 1'b0;
    end
    if (probe_kind_q == tfd_pkg::PROBE_SPARSE && !sparse_hit) begin
      active_w = 1'b0;
    end
    p6_side_d.active = active_w;
    p6_side_d.lat    = p5_lat_q;
  end

  logic                    p6_v_q;
  logic [tfd_pkg::SQW-1:0] p6_sum_q;
  tfd_pkg::tfd_res_side_t  p6_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_s_q    <= cor_side.flip ? -cor_s : cor_s;
      p1_c_q    <= cor_side.flip ? -cor_c : cor_c;
      p1_side_q <= cor_side;
      p2_ps_q   <= rad45 * 45'(p1_s_q);
      p2_pc_q   <= rad45 * 45'(p1_c_q);
      p2_side_q <= p1_side_q;
      p3_dx_q   <= dx_d;
      p3_dz_q   <= dz_d;
      p3_e_q    <= p2_side_q.element;
      p4_ax_q   <= ax_w[tfd_pkg::AW-1:0];
      p4_az_q   <= az_w[tfd_pkg::AW-1:0];
      p4_e_q    <= p3_e_q;
      p5_sqx_q  <= 46'(p4_ax_q) * 46'(p4_ax_q);
      p5_sqz_q  <= 46'(p4_az_q) * 46'(p4_az_q);
      p5_apt_q  <= 34'({p4_ax_q, 1'b0}) * 34'(f_number_q);
      p5_az16_q <= {p4_az_q, 4'd0};
      p5_lat_q  <= lat_sat;
      p5_e_q    <= p4_e_q;
      p6_sum_q  <= tfd_pkg::SQW'(p5_sqx_q) + tfd_pkg::SQW'(p5_sqz_q);
      p6_side_q <= p6_side_d;
    end
  end

  // ---------------------------------------------------------------
  // Distance
  // ---------------------------------------------------------------
  logic                   sq_v;
  logic [tfd_pkg::RW-1:0] sq_root;
  tfd_pkg::tfd_res_side_t sq_side;

  tfd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p6_v_q),
    .value_i (p6_sum_q),
    .side_i  (p6_side_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Q1: distance times slowness
  logic                   q1_v_q;
  logic [41:0]            q1_prod_q;
  tfd_pkg::tfd_res_side_t q1_side_q;

  // Q2: round, saturate, mask -> output register
  logic [41:0] dly_w;
  logic [17:0] dly_sat;

  assign dly_w   = (q1_prod_q + 42'd524288) >> 20;
  assign dly_sat = (dly_w > 42'(tfd_pkg::SAT18)) ? tfd_pkg::SAT18 : dly_w[17:0];

  logic [17:0] out_delay_q, out_lat_q;
  logic        out_active_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_prod_q    <= 42'(sq_root) * 42'(slowness_q);
      q1_side_q    <= sq_side;
      out_delay_q  <= q1_side_q.active ? dly_sat : '0;
      out_active_q <= q1_side_q.active;
      out_lat_q    <= q1_side_q.lat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      p5_v_q  <= 1'b0;
      p6_v_q  <= 1'b0;
      q1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q  <= cor_v;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      p5_v_q  <= p4_v_q;
      p6_v_q  <= p5_v_q;
      q1_v_q  <= sq_v;
      out_v_q <= q1_v_q;
    end
  end

  assign dout_o.valid             = out_v_q;
  assign dout_o.delay_ns          = out_delay_q;
  assign dout_o.active            = out_active_q;
  assign dout_o.lateral_offset_um = out_lat_q;

endmodule

// ----- hdl/tfd_cordic.sv -----
// tfd_cordic: rotation-mode CORDIC, one register stage per iteration.
// Uses tfd_pkg for widths, gain and arctangent table.
module tfd_cordic #(
  parameter int unsigned STAGES = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [tfd_pkg::CW-1:0] angle_i,
  input  tfd_pkg::tfd_geo_side_t        side_i,
  output logic                          valid_o,
  output logic signed [tfd_pkg::CW-1:0] cos_o,
  output logic signed [tfd_pkg::CW-1:0] sin_o,
  output tfd_pkg::tfd_geo_side_t        side_o
);

  logic                          v_q    [STAGES];
  logic signed [tfd_pkg::CW-1:0] x_q    [STAGES];
  logic signed [tfd_pkg::CW-1:0] y_q    [STAGES];
  logic signed [tfd_pkg::CW-1:0] a_q    [STAGES];
  tfd_pkg::tfd_geo_side_t        side_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [tfd_pkg::CW-1:0] ATAN = tfd_pkg::atan_q24(i);
    logic                          vin;
    logic signed [tfd_pkg::CW-1:0] xin, yin, ain, x_d, y_d, a_d;
    tfd_pkg::tfd_geo_side_t        sin_w;

    if (i == 0) begin : g_first
      assign vin   = valid_i;
      assign xin   = tfd_pkg::GAIN_Q24;
      assign yin   = '0;
      assign ain   = angle_i;
      assign sin_w = side_i;
    end else begin : g_next
      assign vin   = v_q[i-1];
      assign xin   = x_q[i-1];
      assign yin   = y_q[i-1];
      assign ain   = a_q[i-1];
      assign sin_w = side_q[i-1];
    end

    always_comb begin
      if (ain >= 0) begin
        x_d = xin - (yin >>> i);
        y_d = yin + (xin >>> i);
        a_d = ain - ATAN;
      end else begin
        x_d = xin + (yin >>> i);
        y_d = yin - (xin >>> i);
        a_d = ain + ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= x_d;
        y_q[i]    <= y_d;
        a_q[i]    <= a_d;
        side_q[i] <= sin_w;
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign cos_o   = x_q[STAGES-1];
  assign sin_o   = y_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

// ----- hdl/tfd_isqrt.sv -----
// tfd_isqrt: pipelined integer square root, one root bit per stage.
// Uses tfd_pkg for widths and the side-band type.
module tfd_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [tfd_pkg::SQW-1:0]  value_i,
  input  tfd_pkg::tfd_res_side_t   side_i,
  output logic                     valid_o,
  output logic [tfd_pkg::RW-1:0]   root_o,
  output tfd_pkg::tfd_res_side_t   side_o
);

  localparam int unsigned N = tfd_pkg::RW;

  logic                     v_q    [N];
  logic [tfd_pkg::SQW-1:0]  rem_q  [N];
  logic [tfd_pkg::SQW-1:0]  root_q [N];
  tfd_pkg::tfd_res_side_t   side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [tfd_pkg::SQW-1:0] BIT = tfd_pkg::SQW'(1) << (2 * (N - 1 - i));
    logic                    vin;
    logic [tfd_pkg::SQW-1:0] rin, qin, trial, rem_d, root_d;
    tfd_pkg::tfd_res_side_t  sin_w;

    if (i == 0) begin : g_first
      assign vin   = valid_i;
      assign rin   = value_i;
      assign qin   = '0;
      assign sin_w = side_i;
    end else begin : g_next
      assign vin   = v_q[i-1];
      assign rin   = rem_q[i-1];
      assign qin   = root_q[i-1];
      assign sin_w = side_q[i-1];
    end

    assign trial = qin + BIT;

    always_comb begin
      if (rin >= trial) begin
        rem_d  = rin - trial;
        root_d = (qin >> 1) + BIT;
      end else begin
        rem_d  = rin;
        root_d = qin >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
        side_q[i] <= sin_w;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1][tfd_pkg::RW-1:0];
  assign side_o  = side_q[N-1];

endmodule

// ----- hdl/tfd_front.sv -----
// tfd_front: element index to angle and linear position; angle range reduction
// and quadrant fold ahead of the CORDIC. Uses tfd_pkg.
module tfd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [6:0]                    element_i,
  input  logic signed [17:0]            fx_i,
  input  logic signed [17:0]            fz_i,
  input  logic [7:0]                    element_count_i,
  input  logic [10:0]                   pitch_i,
  input  logic [20:0]                   angle_step_i,
  output logic                          valid_o,
  output logic signed [tfd_pkg::CW-1:0] angle_o,
  output tfd_pkg::tfd_geo_side_t        side_o
);

  // stage 1: k = 2e - (n - 1), |k| * step, k * pitch
  logic signed [9:0]  k;
  logic [7:0]         kmag;
  logic [28:0]        m_d;
  logic signed [20:0] kp_d;

  assign k    = $signed({2'b00, element_i, 1'b0}) - $signed({2'b00, element_count_i}) + 10'sd1;
  assign kmag = k[9] ? 8'(-k) : k[7:0];
  assign m_d  = 29'(angle_step_i) * 29'(kmag);
  assign kp_d = 21'(k) * $signed({10'd0, pitch_i});

  logic               v1_q, neg1_q;
  logic [28:0]        m1_q;
  logic signed [20:0] kp1_q;
  logic [6:0]         e1_q;
  logic signed [17:0] fx1_q, fz1_q;

  // stage 2: round half up of the half angle, linear lateral offset
  logic [29:0]                 ang_w;
  logic signed [tfd_pkg::DW-1:0] lin_d;

  assign ang_w = ({1'b0, m1_q} + 30'd1) >> 1;
  assign lin_d = (tfd_pkg::DW'(fx1_q) <<< 4) - (tfd_pkg::DW'(kp1_q) <<< 3);

  logic                          v2_q, neg2_q;
  logic [27:0]                   ang2_q;
  tfd_pkg::tfd_geo_side_t        s2_q;
  tfd_pkg::tfd_geo_side_t        s2_d;

  always_comb begin
    s2_d         = '0;
    s2_d.element = e1_q;
    s2_d.fx      = fx1_q;
    s2_d.fz      = fz1_q;
    s2_d.lin_dx  = lin_d;
    s2_d.flip    = 1'b0;
  end

  // stage 3: magnitude into (-pi, pi] by whole turns
  logic signed [tfd_pkg::RDW-1:0] a30, r30;

  assign a30 = $signed({2'b00, ang2_q});

  always_comb begin
    priority if (a30 > tfd_pkg::RED_T3) begin
      r30 = a30 - tfd_pkg::RED_S3;
    end else if (a30 > tfd_pkg::RED_T2) begin
      r30 = a30 - tfd_pkg::RED_S2;
    end else if (a30 > tfd_pkg::RED_T1) begin
      r30 = a30 - tfd_pkg::RED_S1;
    end else begin
      r30 = a30;
    end
  end

  logic                          v3_q, neg3_q;
  logic signed [tfd_pkg::CW-1:0] a3_q;
  tfd_pkg::tfd_geo_side_t        s3_q;

  // stage 4: fold into [-pi/2, pi/2], then restore the sign of k
  logic signed [tfd_pkg::CW-1:0] fold;
  logic                          flip;
  tfd_pkg::tfd_geo_side_t        s4_d;

  always_comb begin
    priority if (a3_q > tfd_pkg::HALF_PI_Q24) begin
      fold = a3_q - tfd_pkg::PI_Q24;
      flip = 1'b1;
    end else if (a3_q < -tfd_pkg::HALF_PI_Q24) begin
      fold = a3_q + tfd_pkg::PI_Q24;
      flip = 1'b1;
    end else begin
      fold = a3_q;
      flip = 1'b0;
    end
    s4_d      = s3_q;
    s4_d.flip = flip;
  end

  logic                          v4_q;
  logic signed [tfd_pkg::CW-1:0] a4_q;
  tfd_pkg::tfd_geo_side_t        s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= k[9];
      m1_q   <= m_d;
      kp1_q  <= kp_d;
      e1_q   <= element_i;
      fx1_q  <= fx_i;
      fz1_q  <= fz_i;
      neg2_q <= neg1_q;
      ang2_q <= ang_w[27:0];
      s2_q   <= s2_d;
      neg3_q <= neg2_q;
      a3_q   <= r30[tfd_pkg::CW-1:0];
      s3_q   <= s2_q;
      a4_q   <= neg3_q ? -fold : fold;
      s4_q   <= s4_d;
    end
  end

  assign valid_o = v4_q;
  assign angle_o = a4_q;
  assign side_o  = s4_q;

endmodule
